>>> src/gpr_pkg.sv
// glyph pixel rasterizer package: font table and panel window constants
// no dependencies; used by gpr_glyph_fetch and glyph_pixel_rasterizer
`timescale 1ns / 1ps
`default_nettype none

package gpr_pkg;

   localparam int GLYPH_COUNT    = 96;
   localparam int ROM_COLUMNS    = 6;
   localparam int GLYPH_IDX_W    = 7;
   localparam int COORD_W        = 8;
   localparam int ADDR_W         = 10;

   localparam logic [GLYPH_IDX_W-1:0] SPACE_CODE = 7'h20;
   localparam logic [ADDR_W-1:0]      COL_BASE   = 10'h034;
   localparam logic [ADDR_W-1:0]      ROW_BASE   = 10'h028;
   localparam logic [ADDR_W-1:0]      WIN_SPAN   = 10'h002;

   typedef logic [7:0] font_col_type;

   localparam font_col_type FONT_ROM [GLYPH_COUNT][ROM_COLUMNS] = '{
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h2f,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h03,8'h00,8'h03,8'h00,8'h00,8'h00}, '{8'h12,8'h3f,8'h12,8'h12,8'h3f,8'h12},
      '{8'h2e,8'h2a,8'h7f,8'h2a,8'h3a,8'h00}, '{8'h23,8'h13,8'h08,8'h04,8'h32,8'h31},
      '{8'h10,8'h2a,8'h25,8'h2a,8'h10,8'h20}, '{8'h02,8'h01,8'h00,8'h00,8'h00,8'h00},
      '{8'h1e,8'h21,8'h00,8'h00,8'h00,8'h00}, '{8'h21,8'h1e,8'h00,8'h00,8'h00,8'h00},
      '{8'h08,8'h2a,8'h1c,8'h2a,8'h08,8'h08}, '{8'h08,8'h08,8'h3e,8'h08,8'h08,8'h08},
      '{8'h80,8'h60,8'h00,8'h00,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08,8'h00},
      '{8'h30,8'h30,8'h00,8'h00,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02,8'h00},
      '{8'h1e,8'h31,8'h29,8'h25,8'h23,8'h1e}, '{8'h22,8'h21,8'h3f,8'h20,8'h20,8'h20},
      '{8'h32,8'h29,8'h29,8'h29,8'h29,8'h26}, '{8'h12,8'h21,8'h21,8'h25,8'h25,8'h1a},
      '{8'h18,8'h14,8'h12,8'h3f,8'h10,8'h10}, '{8'h17,8'h25,8'h25,8'h25,8'h25,8'h19},
      '{8'h1e,8'h25,8'h25,8'h25,8'h25,8'h18}, '{8'h01,8'h01,8'h31,8'h09,8'h05,8'h03},
      '{8'h1a,8'h25,8'h25,8'h25,8'h25,8'h1a}, '{8'h06,8'h29,8'h29,8'h29,8'h29,8'h1e},
      '{8'h24,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h80,8'h64,8'h00,8'h00,8'h00,8'h00},
      '{8'h08,8'h14,8'h22,8'h00,8'h00,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14,8'h00},
      '{8'h22,8'h14,8'h08,8'h00,8'h00,8'h00}, '{8'h02,8'h01,8'h01,8'h29,8'h05,8'h02},
      '{8'h1e,8'h21,8'h2d,8'h2b,8'h2d,8'h0e}, '{8'h3e,8'h09,8'h09,8'h09,8'h09,8'h3e},
      '{8'h3f,8'h25,8'h25,8'h25,8'h25,8'h1a}, '{8'h1e,8'h21,8'h21,8'h21,8'h21,8'h12},
      '{8'h3f,8'h21,8'h21,8'h21,8'h12,8'h0c}, '{8'h3f,8'h25,8'h25,8'h25,8'h25,8'h21},
      '{8'h3f,8'h05,8'h05,8'h05,8'h05,8'h01}, '{8'h1e,8'h21,8'h21,8'h21,8'h29,8'h1a},
      '{8'h3f,8'h04,8'h04,8'h04,8'h04,8'h3f}, '{8'h21,8'h21,8'h3f,8'h21,8'h21,8'h21},
      '{8'h10,8'h20,8'h20,8'h20,8'h20,8'h1f}, '{8'h3f,8'h04,8'h0c,8'h0a,8'h11,8'h20},
      '{8'h3f,8'h20,8'h20,8'h20,8'h20,8'h20}, '{8'h3f,8'h02,8'h04,8'h04,8'h02,8'h3f},
      '{8'h3f,8'h02,8'h04,8'h08,8'h10,8'h3f}, '{8'h1e,8'h21,8'h21,8'h21,8'h21,8'h1e},
      '{8'h3f,8'h09,8'h09,8'h09,8'h09,8'h06}, '{8'h1e,8'h21,8'h29,8'h31,8'h21,8'h1e},
      '{8'h3f,8'h09,8'h09,8'h09,8'h19,8'h26}, '{8'h12,8'h25,8'h25,8'h25,8'h25,8'h18},
      '{8'h01,8'h01,8'h01,8'h3f,8'h01,8'h01}, '{8'h1f,8'h20,8'h20,8'h20,8'h20,8'h1f},
      '{8'h0f,8'h10,8'h20,8'h20,8'h10,8'h0f}, '{8'h1f,8'h20,8'h10,8'h10,8'h20,8'h1f},
      '{8'h21,8'h12,8'h0c,8'h0c,8'h12,8'h21}, '{8'h01,8'h02,8'h0c,8'h38,8'h04,8'h02},
      '{8'h21,8'h31,8'h29,8'h25,8'h23,8'h21}, '{8'h3f,8'h21,8'h00,8'h00,8'h00,8'h00},
      '{8'h02,8'h04,8'h08,8'h10,8'h20,8'h00}, '{8'h21,8'h3f,8'h00,8'h00,8'h00,8'h00},
      '{8'h04,8'h02,8'h3f,8'h02,8'h04,8'h00}, '{8'h40,8'h40,8'h40,8'h40,8'h40,8'h40},
      '{8'h01,8'h02,8'h00,8'h00,8'h00,8'h00}, '{8'h10,8'h30,8'h2a,8'h2a,8'h3c,8'h00},
      '{8'h3f,8'h24,8'h24,8'h24,8'h18,8'h00}, '{8'h0c,8'h14,8'h22,8'h22,8'h00,8'h00},
      '{8'h18,8'h24,8'h24,8'h24,8'h3f,8'h00}, '{8'h1c,8'h2c,8'h2a,8'h2a,8'h24,8'h00},
      '{8'h3e,8'h05,8'h01,8'h00,8'h00,8'h00}, '{8'h18,8'h28,8'ha4,8'ha4,8'h7c,8'h00},
      '{8'h3f,8'h04,8'h04,8'h0c,8'h30,8'h00}, '{8'h24,8'h3d,8'h20,8'h00,8'h00,8'h00},
      '{8'h20,8'h40,8'h40,8'h3d,8'h00,8'h00}, '{8'h3f,8'h0c,8'h12,8'h20,8'h00,8'h00},
      '{8'h1f,8'h20,8'h20,8'h00,8'h00,8'h00}, '{8'h3e,8'h02,8'h3c,8'h02,8'h3c,8'h00},
      '{8'h3e,8'h02,8'h02,8'h02,8'h3c,8'h00}, '{8'h0c,8'h14,8'h22,8'h32,8'h0c,8'h00},
      '{8'hfc,8'h24,8'h24,8'h24,8'h18,8'h00}, '{8'h18,8'h24,8'h24,8'h24,8'hfc,8'h80},
      '{8'h3c,8'h04,8'h02,8'h02,8'h00,8'h00}, '{8'h24,8'h2c,8'h2a,8'h2a,8'h10,8'h00},
      '{8'h02,8'h1f,8'h22,8'h20,8'h00,8'h00}, '{8'h1e,8'h20,8'h20,8'h20,8'h1e,8'h00},
      '{8'h06,8'h18,8'h20,8'h18,8'h06,8'h00}, '{8'h1e,8'h30,8'h1c,8'h30,8'h0e,8'h00},
      '{8'h22,8'h14,8'h08,8'h14,8'h22,8'h00}, '{8'h0c,8'h10,8'ha0,8'ha0,8'h7c,8'h00},
      '{8'h22,8'h32,8'h2a,8'h26,8'h22,8'h22}, '{8'h0c,8'h3f,8'h21,8'h00,8'h00,8'h00},
      '{8'h3f,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h21,8'h3f,8'h0c,8'h00,8'h00,8'h00},
      '{8'h02,8'h01,8'h02,8'h01,8'h00,8'h00}, '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
   };

endpackage

`default_nettype wire

>>> src/gpr_glyph_fetch.sv
// glyph fetch: maps a character code to its font table entry and packs the
// scanned glyph bits, column-major, bit 0 of column 0 first; uses gpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gpr_glyph_fetch #(
   parameter int GLYPH_COLUMNS = 6,
   parameter int GLYPH_ROWS    = 8
) (
   input  wire logic [7:0]                            char_code,
   output logic      [GLYPH_COLUMNS*GLYPH_ROWS-1:0]   glyph_bits
);
   import gpr_pkg::*;

   logic [GLYPH_IDX_W-1:0] code;
   logic [GLYPH_IDX_W-1:0] glyph;

   assign code  = char_code[GLYPH_IDX_W-1:0];
   // control codes fall back to the blank glyph
   assign glyph = (code >= SPACE_CODE) ? code - SPACE_CODE : '0;

   for (genvar c = 0; c < GLYPH_COLUMNS; c++) begin : g_col
      for (genvar b = 0; b < GLYPH_ROWS; b++) begin : g_bit
         if (c < ROM_COLUMNS) begin : g_rom
            assign glyph_bits[c*GLYPH_ROWS+b] = FONT_ROM[glyph][c][b];
         end else begin : g_pad
            assign glyph_bits[c*GLYPH_ROWS+b] = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

>>> src/glyph_pixel_rasterizer.sv
// glyph pixel rasterizer top: scans one glyph a bit per cycle through a
// shift register and emits one panel window per set bit; uses gpr_pkg, gpr_glyph_fetch
// first window: the glyph is registered into the shift register on accept; when bit 0 of
//   column 0 is set, its window is registered from the first scan step
// input: a new item is accepted only when idle, once the scan of the last item ends
//   after its last set bit (also for a blank glyph); a stalled output freezes the scan
// reset: synchronous, returns the sequencer to idle, clears output valid and string y to zero
`timescale 1ns / 1ps
`default_nettype none

module glyph_pixel_rasterizer #(
   parameter int GLYPH_COLUMNS = 6,
   parameter int GLYPH_ROWS    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // char_code[7:0], x_origin[15:8], y_origin[23:16], string_start[24]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // col_start[9:0], col_end[19:10], row_start[29:20], row_end[39:30]
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast
);
   import gpr_pkg::*;

   localparam int BitCount = GLYPH_COLUMNS * GLYPH_ROWS;
   localparam int RowW     = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [BitCount-1:0]    scan_vec_ff, scan_vec_in;
   logic [RowW-1:0]        bit_ff, bit_in;
   logic [COORD_W-1:0]     xo_ff, xo_in;
   logic [COORD_W-1:0]     x_ff, x_in;
   logic [COORD_W-1:0]     y_ff, y_in;
   logic [COORD_W-1:0]     next_y_ff, next_y_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [ADDR_W-1:0]      col_start_ff, col_start_in;
   logic [ADDR_W-1:0]      row_start_ff, row_start_in;

   logic [BitCount-1:0]    glyph_bits;
   logic [BitCount-1:0]    vec_shift;
   logic [COORD_W-1:0]     y_sel;
   logic                   req_fire;
   logic                   out_free;
   logic                   step;
   logic                   emit;

   gpr_glyph_fetch #(
      .GLYPH_COLUMNS (GLYPH_COLUMNS),
      .GLYPH_ROWS    (GLYPH_ROWS)
   ) u_fetch (
      .char_code  (req_tdata[7:0]),
      .glyph_bits (glyph_bits)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign y_sel      = req_tdata[24] ? req_tdata[23:16] : next_y_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = (state_ff == ST_SCAN) && out_free;
   assign vec_shift  = scan_vec_ff >> 1;
   assign emit       = step && scan_vec_ff[0];

   always_comb begin
      state_in     = state_ff;
      scan_vec_in  = scan_vec_ff;
      bit_in       = bit_ff;
      xo_in        = xo_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      next_y_in    = next_y_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      col_start_in = col_start_ff;
      row_start_in = row_start_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               scan_vec_in = glyph_bits;
               bit_in      = '0;
               xo_in       = req_tdata[15:8];
               x_in        = req_tdata[15:8];
               y_in        = y_sel;
               next_y_in   = y_sel + COORD_W'(GLYPH_COLUMNS + 1);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step) begin
               scan_vec_in = vec_shift;
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = (vec_shift == '0);
                  col_start_in = COL_BASE + {1'b0, x_ff, 1'b0};
                  row_start_in = ROW_BASE + {1'b0, y_ff, 1'b0};
               end
               if (bit_ff == RowW'(GLYPH_ROWS - 1)) begin
                  bit_in = '0;
                  x_in   = xo_ff;
                  y_in   = y_ff + COORD_W'(1);
               end else begin
                  bit_in = bit_ff + RowW'(1);
                  x_in   = x_ff + COORD_W'(1);
               end
               if (vec_shift == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_y_ff    <= next_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_vec_ff  <= scan_vec_in;
      bit_ff       <= bit_in;
      xo_ff        <= xo_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      rsp_last_ff  <= rsp_last_in;
      col_start_ff <= col_start_in;
      row_start_ff <= row_start_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {row_start_ff + WIN_SPAN, row_start_ff,
                        col_start_ff + WIN_SPAN, col_start_ff};

   // scan ends once no set bits remain
   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && out_free && vec_shift == '0) |=> (state_ff == ST_IDLE))
      else $error("scan did not end after last set bit");

   // an accepted item blocks the input until its scan ends
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input ready right after accept");

   // a window marked last leaves nothing more to scan
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && vec_shift == '0) |=> (rsp_tvalid && rsp_tlast && state_ff == ST_IDLE))
      else $error("last window not flagged at end of glyph");

endmodule

`default_nettype wire

>>> tb/sv/glyph_window_checker.sv
// glyph window checker: watches both streams of glyph_pixel_rasterizer, predicts the
// panel windows of every accepted character and compares them in order; uses gpr_pkg
`timescale 1ns / 1ps

module glyph_window_checker #(
   parameter int GLYPH_COLUMNS = 6,
   parameter int GLYPH_ROWS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // char_code[7:0], x_origin[15:8], y_origin[23:16], string_start[24]
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // col_start[9:0], col_end[19:10], row_start[29:20], row_end[39:30]
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);
   import gpr_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] col_start;
      logic [ADDR_W-1:0] col_end;
      logic [ADDR_W-1:0] row_start;
      logic [ADDR_W-1:0] row_end;
      logic              last;
   } window_type;

   window_type         windows_due[$];
   logic [COORD_W-1:0] y_cursor;

   task automatic rasterize_char(input logic [31:0] word);
      logic [GLYPH_IDX_W-1:0] code;
      logic [COORD_W-1:0]     x_org;
      logic [COORD_W-1:0]     y_org;
      logic [COORD_W-1:0]     xs;
      logic [COORD_W-1:0]     ys;
      font_col_type           column;
      int                     glyph;
      logic                   have;
      window_type             held;
      window_type             w;
      code   = word[6:0];
      x_org  = word[15:8];
      y_org  = word[24] ? word[23:16] : y_cursor;
      glyph  = (code >= SPACE_CODE) ? int'(code - SPACE_CODE) : 0;
      y_cursor = y_org + 8'(GLYPH_COLUMNS + 1);
      have   = 1'b0;
      held   = '0;
      for (int c = 0; c < GLYPH_COLUMNS; c++) begin
         column = (c < ROM_COLUMNS) ? FONT_ROM[glyph][c] : '0;
         for (int b = 0; b < GLYPH_ROWS && b < 8; b++) begin
            if (column[b]) begin
               xs = x_org + 8'(b);
               ys = y_org + 8'(c);
               w.col_start = COL_BASE + {1'b0, xs, 1'b0};
               w.col_end   = w.col_start + WIN_SPAN;
               w.row_start = ROW_BASE + {1'b0, ys, 1'b0};
               w.row_end   = w.row_start + WIN_SPAN;
               w.last      = 1'b0;
               if (have)
                  windows_due.push_back(held);
               held = w;
               have = 1'b1;
            end
         end
      end
      if (have) begin
         held.last = 1'b1;
         windows_due.push_back(held);
      end
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   // sample at the falling edge, where both streams are settled for the next rising edge
   always @(negedge clock) begin
      window_type exp_w;
      if (reset) begin
         y_cursor   = '0;
         fail_count = 0;
         windows_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (windows_due.size() == 0) begin
               $error("unexpected window item: tdata %h tlast %b", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               exp_w = windows_due.pop_front();
               check_field("col_start", exp_w.col_start, rsp_tdata[9:0]);
               check_field("col_end", exp_w.col_end, rsp_tdata[19:10]);
               check_field("row_start", exp_w.row_start, rsp_tdata[29:20]);
               check_field("row_end", exp_w.row_end, rsp_tdata[39:30]);
               check_field("last_pixel", exp_w.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready)
            rasterize_char(req_tdata);
      end
      pending = windows_due.size();
   end

endmodule

>>> tb/sv/testbench.sv
// testbench top for glyph_pixel_rasterizer: drives character items with random gaps
// and output stalls, and reports the verdict of glyph_window_checker; uses gpr_pkg
`timescale 1ns / 1ps

module testbench;

   localparam int RUN_LIMIT    = 400000;
   localparam int TOTAL_ITEMS  = 150;
   localparam int CALM_ITEMS   = 125;
   localparam int HOLD_AT      = 50;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 64;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   int   fails;
   int   pending;
   int   sent     = 0;
   int   cycles   = 0;
   logic calm     = 1'b0;

   glyph_pixel_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   glyph_window_checker u_window_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fails),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // window receiver: random stalls, one long hold once enough items went in
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (!hold_done && sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge clock);
         end
      end
   end

   task automatic send_char(input logic [7:0] code, input logic [7:0] x,
                            input logic [7:0] y, input logic start);
      logic taken;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, start, y, x, code};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      sent++;
      if (sent >= CALM_ITEMS)
         calm = 1'b1;
      if (!calm && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(9, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_code();
      logic [7:0] code;
      code[7]   = 1'($urandom_range(1));
      code[6:0] = 7'($urandom_range(126, 32));
      return code;
   endfunction

   initial begin
      logic [7:0] y;
      int         len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // blank glyphs: control codes, space, delete, and delete with bit 7 set
      send_char(8'h00, 8'h00, 8'h00, 1'b0);
      send_char(8'h1F, 8'h10, 8'h20, 1'b1);
      send_char(8'h20, 8'h30, 8'h40, 1'b0);
      send_char(8'h7F, 8'h50, 8'h60, 1'b1);
      send_char(8'hFF, 8'hFF, 8'hFF, 1'b0);
      // printable glyphs, bit 7 ignored
      send_char(8'h21, 8'h00, 8'h00, 1'b1);
      send_char(8'hA1, 8'h00, 8'h00, 1'b1);
      send_char(8'h23, 8'h05, 8'h09, 1'b1);
      send_char(8'h40, 8'h05, 8'h09, 1'b0);
      send_char(8'h42, 8'h05, 8'h09, 1'b0);
      send_char(8'h4D, 8'h80, 8'h7F, 1'b1);
      // glyph bit 7 set
      send_char(8'h70, 8'h11, 8'h22, 1'b1);
      send_char(8'h67, 8'h11, 8'h22, 1'b0);
      send_char(8'h71, 8'h11, 8'h22, 1'b0);
      send_char(8'h2C, 8'h11, 8'h22, 1'b0);
      // origin wrap on both axes
      send_char(8'h7E, 8'hFE, 8'hFD, 1'b1);
      send_char(8'h30, 8'hFB, 8'hFC, 1'b1);
      send_char(8'h5F, 8'hFF, 8'hFF, 1'b1);
      send_char(8'hC5, 8'hFA, 8'hFA, 1'b0);
      send_char(8'h38, 8'h00, 8'hF9, 1'b1);
      send_char(8'h38, 8'hFF, 8'h00, 1'b0);
      send_char(8'h7D, 8'hAA, 8'h55, 1'b1);
      send_char(8'h5B, 8'h55, 8'hAA, 1'b0);

      while (sent < TOTAL_ITEMS) begin
         if ($urandom_range(4) == 0) begin
            send_char(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
         end else begin
            y   = 8'($urandom);
            len = $urandom_range(8, 1);
            send_char(pick_code(), 8'($urandom), y, 1'b1);
            for (int i = 1; i < len; i++)
               send_char(pick_code(), 8'($urandom), 8'($urandom), 1'b0);
         end
         if (sent >= 100 && sent < 110) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
